// ===== hdl/ira_pkg.sv =====
`timescale 1ns / 1ps
// ira_pkg: widths, character constants and shared types for the integer to
// ascii formatter. No dependencies; every other file of the block but ira_ram imports it.
package ira_pkg;

  // value width and the widths that follow from it
  localparam int VALUE_WIDTH    = 32;
  localparam int RADIX_W        = 5;
  localparam int DIGIT_W        = 4;
  localparam int CHAR_W         = 8;
  localparam int CNT_W          = $clog2(VALUE_WIDTH + 1);
  localparam int ADDR_W         = $clog2(VALUE_WIDTH);

  // divider geometry: quotient bits resolved per cycle
  localparam int BITS_PER_CYCLE = 8;
  localparam int DIV_CYCLES     = (VALUE_WIDTH + BITS_PER_CYCLE - 1) / BITS_PER_CYCLE;
  localparam int DIV_WIDTH      = DIV_CYCLES * BITS_PER_CYCLE;
  localparam int DIV_CNT_W      = $clog2(DIV_CYCLES + 1);

  // legal number bases
  localparam logic [RADIX_W-1:0] RADIX_MIN = 5'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX = 5'd16;

  // ascii codes
  localparam logic [CHAR_W-1:0] CHAR_MINUS   = 8'h2D;
  localparam logic [CHAR_W-1:0] CHAR_ZERO    = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
  localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;

  typedef logic [CHAR_W-1:0] char_t;

  // result of one division pass
  typedef struct packed {
    logic                   done;
    logic [VALUE_WIDTH-1:0] quotient;
    logic [DIGIT_W-1:0]     remainder;
  } div_res_t;

  // digit to ascii, '0'..'9' then 'a'..'f' or 'A'..'F'
  function automatic char_t digit_char(input logic [DIGIT_W-1:0] d, input logic upper);
    char_t c;
    if (d < 4'd10) begin
      c = CHAR_ZERO + char_t'(d);
    end else if (upper) begin
      c = CHAR_UPPER_A + char_t'(d - 4'd10);
    end else begin
      c = CHAR_LOWER_A + char_t'(d - 4'd10);
    end
    return c;
  endfunction

endpackage

// ===== hdl/ira_if.sv =====
`timescale 1ns / 1ps
// ira_in_if and ira_out_if: valid/ready channels for number beats and for
// character beats. Depends on ira_pkg for the field widths.
interface ira_in_if import ira_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [VALUE_WIDTH-1:0] value;
  logic [RADIX_W-1:0]     radix;
  logic                   uppercase;
  logic                   signed_mode;

  modport source (output valid, value, radix, uppercase, signed_mode, input ready);
  modport sink   (input valid, value, radix, uppercase, signed_mode, output ready);
endinterface

interface ira_out_if import ira_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] character;
  logic              last;

  modport source (output valid, character, last, input ready);
  modport sink   (input valid, character, last, output ready);
endinterface

// ===== hdl/integer_radix_to_ascii.sv =====
`timescale 1ns / 1ps
// Formats one integer per input beat as ASCII text in base 2..16, most
// significant digit first, one character per output beat, last set on the
// final character; a negative value in signed mode leads with '-'. A beat
// with a radix outside 2..16 is taken and dropped with no output. Each number
// is handled alone: in_item.ready is high only while the block is idle. The
// digits come from one shared divider that resolves 8 quotient bits a cycle,
// each digit being stored least significant first, and the digit store is
// then read back most significant first, one character per read. The '-' is
// sent from the sign state, between the last division and the first digit,
// and adds no time when the sink never stalls.
// Depends on ira_pkg, ira_if, ira_ram and ira_divider.
module integer_radix_to_ascii import ira_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  ira_in_if.sink      in_item,
  ira_out_if.source   out_item
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_START = 3'd1;
  localparam logic [2:0] S_WAIT  = 3'd2;
  localparam logic [2:0] S_SIGN  = 3'd3;
  localparam logic [2:0] S_LOAD  = 3'd4;
  localparam logic [2:0] S_READ  = 3'd5;

  logic [2:0]             state_r,     state_nxt;
  logic [VALUE_WIDTH-1:0] quo_r,       quo_nxt;
  logic [RADIX_W-1:0]     radix_r,     radix_nxt;
  logic                   upper_r,     upper_nxt;
  logic                   neg_r,       neg_nxt;
  logic [CNT_W-1:0]       cnt_r,       cnt_nxt;
  logic [ADDR_W-1:0]      idx_r,       idx_nxt;
  logic                   out_valid_r, out_valid_nxt;
  char_t                  out_char_r,  out_char_nxt;
  logic                   out_last_r,  out_last_nxt;

  logic                   div_start;
  div_res_t               div_res;
  logic                   ram_we;
  logic [DIGIT_W-1:0]     ram_rdata;
  logic                   out_free;
  logic                   in_neg;

  // shared divider
  ira_divider u_divider (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (quo_r),
    .divisor  (radix_r),
    .res      (div_res)
  );

  // digit store, least significant digit at address zero
  ira_ram #(
    .WIDTH (DIGIT_W),
    .DEPTH (VALUE_WIDTH)
  ) u_digit_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cnt_r[ADDR_W-1:0]),
    .wdata (div_res.remainder),
    .raddr (idx_r),
    .rdata (ram_rdata)
  );

  assign out_free       = !out_valid_r || out_item.ready;
  assign in_neg         = in_item.signed_mode && in_item.value[VALUE_WIDTH-1];
  assign in_item.ready  = (state_r == S_IDLE);

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    quo_nxt       = quo_r;
    radix_nxt     = radix_r;
    upper_nxt     = upper_r;
    neg_nxt       = neg_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r && !out_item.ready;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    div_start     = 1'b0;
    ram_we        = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_item.valid && in_item.radix >= RADIX_MIN && in_item.radix <= RADIX_MAX) begin
          quo_nxt   = in_neg ? ('0 - in_item.value) : in_item.value;
          radix_nxt = in_item.radix;
          upper_nxt = in_item.uppercase;
          neg_nxt   = in_neg;
          cnt_nxt   = '0;
          state_nxt = S_START;
        end
      end
      S_START: begin
        div_start = 1'b1;
        state_nxt = S_WAIT;
      end
      S_WAIT: begin
        // store one digit and go on while the quotient is nonzero
        if (div_res.done) begin
          ram_we  = 1'b1;
          cnt_nxt = cnt_r + 1'b1;
          quo_nxt = div_res.quotient;
          if (div_res.quotient == '0 || cnt_nxt == CNT_W'(VALUE_WIDTH)) begin
            idx_nxt   = cnt_r[ADDR_W-1:0];
            state_nxt = S_SIGN;
          end else begin
            state_nxt = S_START;
          end
        end
      end
      S_SIGN: begin
        if (!neg_r) begin
          state_nxt = S_LOAD;
        end else if (out_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = CHAR_MINUS;
          out_last_nxt  = 1'b0;
          state_nxt     = S_LOAD;
        end
      end
      S_LOAD: begin
        // digits leave most significant first
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = digit_char(ram_rdata, upper_r);
          out_last_nxt  = (idx_r == '0);
          if (idx_r == '0) begin
            state_nxt = S_IDLE;
          end else begin
            idx_nxt   = idx_r - 1'b1;
            state_nxt = S_READ;
          end
        end
      end
      S_READ: begin
        state_nxt = S_LOAD;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // working and payload registers
  always_ff @(posedge clk) begin
    quo_r      <= quo_nxt;
    radix_r    <= radix_nxt;
    upper_r    <= upper_nxt;
    neg_r      <= neg_nxt;
    idx_r      <= idx_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_item.valid     = out_valid_r;
  assign out_item.character = out_char_r;
  assign out_item.last      = out_last_r;

  // a character that is not the last one means the number is still being sent
  a_mid_text_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_last_r |-> state_r != S_IDLE)
    else $error("non-final character held while idle");

  // the divider only finishes while the sequencer waits for it
  a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_res.done |-> state_r == S_WAIT)
    else $error("divider done outside wait");

  // a stored digit lies below the radix
  a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
    div_res.done |-> div_res.remainder < radix_r)
    else $error("digit not below radix");

  // the digit store never overflows
  a_store_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> cnt_r < CNT_W'(VALUE_WIDTH))
    else $error("digit store overflow");

endmodule

// ===== hdl/ira_ram.sv =====
`timescale 1ns / 1ps
// ira_ram: generic single-write, single-read memory with registered read data.
// No dependencies.
module ira_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/ira_divider.sv =====
`timescale 1ns / 1ps
// ira_divider: iterative restoring divider of the value by the radix,
// BITS_PER_CYCLE quotient bits per cycle. Depends on ira_pkg.
module ira_divider import ira_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [VALUE_WIDTH-1:0] dividend,
  input  logic [RADIX_W-1:0]     divisor,
  output div_res_t               res
);

  logic [DIV_WIDTH-1:0] work_r;
  logic [DIV_WIDTH-1:0] work_nxt;
  logic [DIGIT_W-1:0]   rem_r;
  logic [DIGIT_W-1:0]   rem_nxt;
  logic [RADIX_W-1:0]   den_r;
  logic [DIV_CNT_W-1:0] step_r;
  logic                 busy_r;
  logic                 done_r;

  // BITS_PER_CYCLE steps of shift, compare and subtract; partial remainder stays below the radix
  always_comb begin
    logic [RADIX_W-1:0] trial;
    rem_nxt  = rem_r;
    work_nxt = work_r;
    for (int i = 0; i < BITS_PER_CYCLE; i++) begin
      trial    = {rem_nxt, work_nxt[DIV_WIDTH-1]};
      work_nxt = {work_nxt[DIV_WIDTH-2:0], 1'b0};
      if (trial >= den_r) begin
        trial       = trial - den_r;
        work_nxt[0] = 1'b1;
      end
      rem_nxt = trial[DIGIT_W-1:0];
    end
  end

  // operands and partial results
  always_ff @(posedge clk) begin
    if (start) begin
      work_r <= DIV_WIDTH'(dividend);
      rem_r  <= '0;
      den_r  <= divisor;
    end else if (busy_r) begin
      work_r <= work_nxt;
      rem_r  <= rem_nxt;
    end
  end

  // step counter and done pulse
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 1'b1;
        if (step_r == DIV_CNT_W'(DIV_CYCLES - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign res.done      = done_r;
  assign res.quotient  = work_r[VALUE_WIDTH-1:0];
  assign res.remainder = rem_r;

endmodule
